@@ hdl/cesd_pkg.sv @@
// Shared types, character codes and hex helper for the C string escape decoder.
package cesd_pkg;

    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_X      = 8'h78;
    localparam logic [7:0] C_ZERO   = 8'h30;
    localparam logic [7:0] C_N      = 8'h6E;
    localparam logic [7:0] C_R      = 8'h72;
    localparam logic [7:0] C_F      = 8'h66;
    localparam logic [7:0] C_V      = 8'h76;
    localparam logic [7:0] C_B      = 8'h62;
    localparam logic [7:0] C_T      = 8'h74;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_NUL    = 8'h00;

    localparam logic [7:0] C_LF = 8'h0A;
    localparam logic [7:0] C_CR = 8'h0D;
    localparam logic [7:0] C_FF = 8'h0C;
    localparam logic [7:0] C_VT = 8'h0B;
    localparam logic [7:0] C_BS = 8'h08;
    localparam logic [7:0] C_HT = 8'h09;

    localparam int unsigned GROUP_MAX = 4;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_HEX1  = 2'd2,
        MODE_HEX2  = 2'd3
    } t_mode;

    // Bytes produced by one input item, in output order.
    typedef struct packed {
        logic [GROUP_MAX-1:0][7:0] data;
        logic [GROUP_MAX-1:0]      last;
        logic [2:0]                cnt;
    } t_group;

    // {valid, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

@@ hdl/c_escape_string_decoder.sv @@
// Top level: streaming C string escape decoder with a four-byte output buffer.
// An item's first decoded byte is on m_tdata in the cycle after the item is accepted.
// Throughput: one item per cycle while each item yields at most one byte and m_tready
//   is high; an item that yields more bytes holds s_tready low while the buffer drains.
// A no-byte item (backslash, 'x', first hex digit) is taken every cycle once drained.
// Reset (i_rst_n low, synchronous) returns to plain text mode and empties the buffer.
module c_escape_string_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_string
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // last
);

    cesd_pkg::t_mode  r_mode;
    cesd_pkg::t_mode  n_mode;
    logic [7:0]       r_held;
    logic [7:0]       n_held;
    logic             held_we;
    cesd_pkg::t_group dec_group;
    cesd_pkg::t_group r_grp;

    logic in_acc;
    logic out_pop;

    // Escape decode of the incoming byte against the current mode.
    cesd_decode u_decode (
        .i_mode    (r_mode),
        .i_held    (r_held),
        .i_byte    (s_tdata),
        .i_end     (s_tlast),
        .o_mode    (n_mode),
        .o_held    (n_held),
        .o_held_we (held_we),
        .o_group   (dec_group)
    );

    // Output buffer: entry 0 is on the bus; it shifts down on each pop.
    assign m_tvalid = (r_grp.cnt != 3'd0);
    assign m_tdata  = r_grp.data[0];
    assign m_tlast  = r_grp.last[0];
    assign out_pop  = m_tvalid && m_tready;

    // Take a new item once the buffer is empty or its last byte leaves now.
    assign s_tready = (r_grp.cnt == 3'd0) || ((r_grp.cnt == 3'd1) && m_tready);
    assign in_acc   = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= cesd_pkg::MODE_PLAIN;
            r_grp.cnt <= 3'd0;
        end else begin
            if (in_acc) begin
                r_mode <= n_mode;
                r_grp  <= dec_group;
            end else if (out_pop) begin
                r_grp.data <= {8'h00, r_grp.data[cesd_pkg::GROUP_MAX-1:1]};
                r_grp.last <= {1'b0, r_grp.last[cesd_pkg::GROUP_MAX-1:1]};
                r_grp.cnt  <= r_grp.cnt - 3'd1;
            end
        end
    end

    // Held first hex digit; payload only.
    always_ff @(posedge i_clk) begin
        if (in_acc && held_we) begin
            r_held <= n_held;
        end
    end

endmodule

@@ hdl/cesd_decode.sv @@
// Combinational escape decode of one input item into a group of output bytes.
module cesd_decode (
    input  cesd_pkg::t_mode  i_mode,
    input  logic [7:0]       i_held,
    input  logic [7:0]       i_byte,
    input  logic             i_end,
    output cesd_pkg::t_mode  o_mode,
    output logic [7:0]       o_held,
    output logic             o_held_we,
    output cesd_pkg::t_group o_group
);

    logic       is_end;
    logic [4:0] hv_hi;
    logic [4:0] hv_lo;
    logic [7:0] hex_byte;

    assign is_end   = i_end || (i_byte == cesd_pkg::C_NUL);
    assign hv_hi    = cesd_pkg::hex_value(i_held);
    assign hv_lo    = cesd_pkg::hex_value(i_byte);
    assign hex_byte = {hv_hi[3:0], hv_lo[3:0]};
    assign o_held   = i_byte;

    always_comb begin
        o_group   = '0;
        o_mode    = i_mode;
        o_held_we = 1'b0;
        if (is_end) begin
            o_mode = cesd_pkg::MODE_PLAIN;
            unique case (i_mode)
                cesd_pkg::MODE_ESC: begin
                    o_group.data[0] = cesd_pkg::C_BSLASH;
                    o_group.data[1] = cesd_pkg::C_NUL;
                    o_group.last[1] = 1'b1;
                    o_group.cnt     = 3'd2;
                end
                cesd_pkg::MODE_HEX1: begin
                    o_group.data[0] = cesd_pkg::C_BSLASH;
                    o_group.data[1] = cesd_pkg::C_X;
                    o_group.data[2] = cesd_pkg::C_NUL;
                    o_group.last[2] = 1'b1;
                    o_group.cnt     = 3'd3;
                end
                cesd_pkg::MODE_HEX2: begin
                    o_group.data[0] = cesd_pkg::C_BSLASH;
                    o_group.data[1] = cesd_pkg::C_X;
                    o_group.data[2] = i_held;
                    o_group.data[3] = cesd_pkg::C_NUL;
                    o_group.last[3] = 1'b1;
                    o_group.cnt     = 3'd4;
                end
                default: begin
                    o_group.data[0] = cesd_pkg::C_NUL;
                    o_group.last[0] = 1'b1;
                    o_group.cnt     = 3'd1;
                end
            endcase
        end else begin
            unique case (i_mode)
                cesd_pkg::MODE_PLAIN: begin
                    if (i_byte == cesd_pkg::C_BSLASH) begin
                        o_mode = cesd_pkg::MODE_ESC;
                    end else begin
                        o_group.data[0] = i_byte;
                        o_group.cnt     = 3'd1;
                    end
                end
                cesd_pkg::MODE_ESC: begin
                    o_mode      = cesd_pkg::MODE_PLAIN;
                    o_group.cnt = 3'd1;
                    unique case (i_byte)
                        cesd_pkg::C_N:      o_group.data[0] = cesd_pkg::C_LF;
                        cesd_pkg::C_R:      o_group.data[0] = cesd_pkg::C_CR;
                        cesd_pkg::C_F:      o_group.data[0] = cesd_pkg::C_FF;
                        cesd_pkg::C_V:      o_group.data[0] = cesd_pkg::C_VT;
                        cesd_pkg::C_B:      o_group.data[0] = cesd_pkg::C_BS;
                        cesd_pkg::C_T:      o_group.data[0] = cesd_pkg::C_HT;
                        cesd_pkg::C_BSLASH: o_group.data[0] = cesd_pkg::C_BSLASH;
                        cesd_pkg::C_SQUOTE: o_group.data[0] = cesd_pkg::C_SQUOTE;
                        cesd_pkg::C_DQUOTE: o_group.data[0] = cesd_pkg::C_DQUOTE;
                        cesd_pkg::C_X: begin
                            o_mode      = cesd_pkg::MODE_HEX1;
                            o_group.cnt = 3'd0;
                        end
                        default: begin
                            o_group.data[0] = cesd_pkg::C_BSLASH;
                            o_group.data[1] = i_byte;
                            o_group.cnt     = 3'd2;
                        end
                    endcase
                end
                cesd_pkg::MODE_HEX1: begin
                    o_held_we = 1'b1;
                    o_mode    = cesd_pkg::MODE_HEX2;
                end
                default: begin
                    o_mode = cesd_pkg::MODE_PLAIN;
                    if (!hv_hi[4] || !hv_lo[4]) begin
                        // bad hex: everything raw
                        o_group.data[0] = cesd_pkg::C_BSLASH;
                        o_group.data[1] = cesd_pkg::C_X;
                        o_group.data[2] = i_held;
                        o_group.data[3] = i_byte;
                        o_group.cnt     = 3'd4;
                    end else if (hex_byte == cesd_pkg::C_NUL) begin
                        // a zero value must not terminate the string
                        o_group.data[0] = cesd_pkg::C_BSLASH;
                        o_group.data[1] = cesd_pkg::C_ZERO;
                        o_group.cnt     = 3'd2;
                    end else begin
                        o_group.data[0] = hex_byte;
                        o_group.cnt     = 3'd1;
                    end
                end
            endcase
        end
    end

endmodule

@@ bench/tb_c_escape_string_decoder.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the streaming C string escape decoder.
module tb_c_escape_string_decoder;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 6;
    localparam int PHASE_ITEMS    = 64;      // random items per idling phase
    localparam int HOLD_CYCLES    = 60;      // long receiver hold-off
    localparam int TAIL_CYCLES    = 8;       // settle time after the final drain
    localparam int TIMEOUT_CYCLES = 200000;

    // Idling phases of the run.
    typedef enum int {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH,
        PH_PRESSURE
    } t_phase;

    // One source byte with its end marker.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       eos;
    } t_src_item;

    // One decoded byte as the block should produce it.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_dec_byte;

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;  // [7:0] in_byte
    logic       s_tlast  = 1'b0;   // end_of_string
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] out_byte
    logic       m_tlast;           // last

    // Idle chance in percent, per phase.
    int send_idle_pct [5] = '{0, 66, 0, 25, 0};
    int recv_stall_pct[5] = '{0, 0, 66, 25, 0};

    t_phase    phase = PH_FREE;
    t_src_item pending_q[$];       // source bytes not yet offered
    t_dec_byte decoded_q[$];       // decoded bytes still to arrive
    t_dec_byte head_byte;
    int        fail_count = 0;
    int        queued     = 0;
    int        hold_left  = 0;
    logic      hold_done  = 1'b0;

    // Decoder shadow state.
    cesd_pkg::t_mode dec_mode = cesd_pkg::MODE_PLAIN;
    logic [7:0]      dec_held = 8'h00;

    string hex_chars = "0123456789abcdefABCDEF";
    logic [7:0] simple_esc[9] = '{cesd_pkg::C_N, cesd_pkg::C_R, cesd_pkg::C_F,
                                  cesd_pkg::C_V, cesd_pkg::C_B, cesd_pkg::C_T,
                                  cesd_pkg::C_BSLASH, cesd_pkg::C_SQUOTE,
                                  cesd_pkg::C_DQUOTE};

    c_escape_string_decoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Hex digit value, -1 when the byte is no hex digit.
    function automatic int nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return int'(c - "0");
        end
        if (c >= "a" && c <= "f") begin
            return int'(c - "a") + 10;
        end
        if (c >= "A" && c <= "F") begin
            return int'(c - "A") + 10;
        end
        return -1;
    endfunction

    function automatic void emit(input logic [7:0] b, input logic lastflag);
        decoded_q.push_back(t_dec_byte'{data: b, last: lastflag});
    endfunction

    // Decode one accepted source item into the bytes it releases.
    function automatic void decode_item(input logic [7:0] c, input logic eos);
        int hi;
        int lo;
        logic [7:0] v;
        // A NUL source byte ends the string just like the end marker.
        if (eos || c == cesd_pkg::C_NUL) begin
            case (dec_mode)
                cesd_pkg::MODE_ESC: begin
                    emit(cesd_pkg::C_BSLASH, 1'b0);
                end
                cesd_pkg::MODE_HEX1: begin
                    emit(cesd_pkg::C_BSLASH, 1'b0);
                    emit(cesd_pkg::C_X, 1'b0);
                end
                cesd_pkg::MODE_HEX2: begin
                    emit(cesd_pkg::C_BSLASH, 1'b0);
                    emit(cesd_pkg::C_X, 1'b0);
                    emit(dec_held, 1'b0);
                end
                default: ;
            endcase
            emit(cesd_pkg::C_NUL, 1'b1);
            dec_mode = cesd_pkg::MODE_PLAIN;
            return;
        end
        case (dec_mode)
            cesd_pkg::MODE_PLAIN: begin
                if (c == cesd_pkg::C_BSLASH) begin
                    dec_mode = cesd_pkg::MODE_ESC;
                end else begin
                    emit(c, 1'b0);
                end
            end
            cesd_pkg::MODE_ESC: begin
                dec_mode = cesd_pkg::MODE_PLAIN;
                case (c) inside
                    cesd_pkg::C_N: emit(cesd_pkg::C_LF, 1'b0);
                    cesd_pkg::C_R: emit(cesd_pkg::C_CR, 1'b0);
                    cesd_pkg::C_F: emit(cesd_pkg::C_FF, 1'b0);
                    cesd_pkg::C_V: emit(cesd_pkg::C_VT, 1'b0);
                    cesd_pkg::C_B: emit(cesd_pkg::C_BS, 1'b0);
                    cesd_pkg::C_T: emit(cesd_pkg::C_HT, 1'b0);
                    cesd_pkg::C_BSLASH, cesd_pkg::C_SQUOTE, cesd_pkg::C_DQUOTE:
                        emit(c, 1'b0);
                    cesd_pkg::C_X: dec_mode = cesd_pkg::MODE_HEX1;
                    default: begin
                        emit(cesd_pkg::C_BSLASH, 1'b0);
                        emit(c, 1'b0);
                    end
                endcase
            end
            cesd_pkg::MODE_HEX1: begin
                dec_held = c;
                dec_mode = cesd_pkg::MODE_HEX2;
            end
            default: begin
                dec_mode = cesd_pkg::MODE_PLAIN;
                hi = nibble(dec_held);
                lo = nibble(c);
                if (hi < 0 || lo < 0) begin
                    // bad hex: all four bytes pass through raw
                    emit(cesd_pkg::C_BSLASH, 1'b0);
                    emit(cesd_pkg::C_X, 1'b0);
                    emit(dec_held, 1'b0);
                    emit(c, 1'b0);
                end else begin
                    v = 8'(hi * 16 + lo);
                    // a zero value would end the string, so it stays escaped
                    if (v == cesd_pkg::C_NUL) begin
                        emit(cesd_pkg::C_BSLASH, 1'b0);
                        emit(cesd_pkg::C_ZERO, 1'b0);
                    end else begin
                        emit(v, 1'b0);
                    end
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers pending items, idles at the phase's rate
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct[phase]) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_q[0].in_byte;
                s_tlast  <= pending_q[0].eos;
                void'(pending_q.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off in the pressure
    // phase so the output buffer fills and intake backs up.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (phase == PH_PRESSURE && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct[phase]);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on input handshakes, checks output handshakes
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                decode_item(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected item: out_byte %02h last %0b", m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    head_byte = decoded_q.pop_front();
                    if (m_tdata !== head_byte.data) begin
                        $error("out_byte: expected %02h actual %02h", head_byte.data, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== head_byte.last) begin
                        $error("last: expected %0b actual %0b", head_byte.last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic send(input logic [7:0] b, input logic eos);
        pending_q.push_back(t_src_item'{in_byte: b, eos: eos});
        queued++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send(s[i], 1'b0);
        end
    endtask

    function automatic logic [7:0] rand_hex_digit();
        return hex_chars[$urandom_range(21)];
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(1, 255));
        end while (nibble(b) >= 0);
        return b;
    endfunction

    // Mostly well-formed escapes with random content, some noise.
    task automatic gen_tokens(input int n_items);
        int start;
        int kind;
        start = queued;
        while (queued - start < n_items) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                send(8'($urandom_range(1, 255)), 1'b0);     // plain, may start an escape
            end else if (kind < 55) begin
                send(cesd_pkg::C_BSLASH, 1'b0);
                send(simple_esc[$urandom_range(8)], 1'b0);
            end else if (kind < 70) begin
                send(cesd_pkg::C_BSLASH, 1'b0);
                send(cesd_pkg::C_X, 1'b0);
                if ($urandom_range(7) == 0) begin
                    send(cesd_pkg::C_ZERO, 1'b0);           // \x00 stays escaped
                    send(cesd_pkg::C_ZERO, 1'b0);
                end else begin
                    send(rand_hex_digit(), 1'b0);
                    send(rand_hex_digit(), 1'b0);
                end
            end else if (kind < 78) begin
                send(cesd_pkg::C_BSLASH, 1'b0);
                send(cesd_pkg::C_X, 1'b0);
                case ($urandom_range(2))
                    0: begin
                        send(rand_non_hex(), 1'b0);
                        send(8'($urandom_range(1, 255)), 1'b0);
                    end
                    1: begin
                        send(rand_hex_digit(), 1'b0);
                        send(rand_non_hex(), 1'b0);
                    end
                    default: begin
                        send(rand_non_hex(), 1'b0);
                        send(rand_non_hex(), 1'b0);
                    end
                endcase
            end else if (kind < 84) begin
                send(cesd_pkg::C_BSLASH, 1'b0);
                send(8'($urandom_range(1, 255)), 1'b0);     // random escape byte
            end else if (kind < 92) begin
                send(8'($urandom_range(255)), 1'b1);        // end item, byte ignored
            end else if (kind < 95) begin
                send(cesd_pkg::C_NUL, 1'b0);                // NUL ends the string
            end else begin
                // escape cut short by the end of the string
                send(cesd_pkg::C_BSLASH, 1'b0);
                if ($urandom_range(1) == 1) begin
                    send(cesd_pkg::C_X, 1'b0);
                    if ($urandom_range(1) == 1) begin
                        send(8'($urandom_range(1, 255)), 1'b0);
                    end
                end
                send(8'($urandom_range(255)), 1'b1);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || s_tvalid || decoded_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: byte extremes, simple escapes, good and zero hex, bad hex,
        // unknown escape, trailing backslash, end after \x and after \x plus one.
        phase = PH_FREE;
        send(8'hFF, 1'b0);
        send(8'h01, 1'b0);
        send_text("\\n\\\"\\xAf\\x00\\xg1\\q\\");
        send(8'hA5, 1'b1);
        send_text("\\x");
        send(cesd_pkg::C_NUL, 1'b0);
        send_text("\\x7");
        send(8'h5A, 1'b1);
        wait_drained();

        for (int p = PH_FREE; p <= PH_PRESSURE; p++) begin
            phase = t_phase'(p);
            gen_tokens(PHASE_ITEMS);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && decoded_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Hang guard.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("simulation failed");
        $finish;
    end

endmodule
